FILE: sv/rpc_pkg.sv
// Shared types, widths, constants and the arctangent table for the point rotation block.
// No dependencies; every other file in sv/ imports this package.
package rpc_pkg;

  localparam int COORD_WIDTH   = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int ANGLE_WIDTH   = 21;

  localparam int PHASE_W = 32;
  localparam int XY_W    = 33;
  localparam int Z_W     = 32;
  localparam int FRAC_W  = 15;
  localparam int TRIG_W  = FRAC_W + 2;
  localparam int DIFF_W  = COORD_WIDTH + 1;
  localparam int PROD_W  = DIFF_W + TRIG_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int MAG_Q_W = SUM_W - FRAC_W;
  localparam int RES_W   = MAG_Q_W + 2;

  localparam int STAGE_IDX_W = $clog2(CORDIC_STAGES);
  localparam int ATAN_IDX_W  = 5;

  // angle reduction
  localparam int U_W           = ANGLE_WIDTH + 1;
  localparam int DEG_TURN      = 92160;
  localparam int DEG_OFFSET    = 12 * DEG_TURN;
  localparam int TURN_HI_SH    = 11;
  localparam int HI_W          = U_W - TURN_HI_SH;
  localparam int DEG_RECIP     = 2913;
  localparam int DEG_RECIP_SH  = 17;
  localparam int QP_W          = HI_W + 12;
  localparam int QD_W          = QP_W - DEG_RECIP_SH;
  localparam int R_W           = 17;
  localparam int PH_MUL        = 46603;
  localparam int M_W           = R_W + 4;
  localparam int PH_REM_RECIP  = 2982617;
  localparam int PH_REM_SH     = 27;
  localparam int P2_W          = M_W + 22;
  localparam int F_W           = P2_W - PH_REM_SH;
  localparam int RAD_TO_PHASE  = 683565276;
  localparam int RAD_SH        = 16;
  localparam int RADP_W        = ANGLE_WIDTH + 31;
  localparam int CORDIC_GAIN   = 652032875;
  localparam logic [PHASE_W-1:0] QUAD_HALF = 32'h2000_0000;

  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // configuration port
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_ROUND = '0;

  typedef struct packed {
    logic signed [DIFF_W-1:0]      dx;
    logic signed [DIFF_W-1:0]      dy;
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
  } side_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic [1:0]             quad;
    logic                   zero;
    side_t                  side;
  } cell_t;

  // atan(2^-i) in 2^-32 turn units
  function automatic logic [Z_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
    logic [Z_W-1:0] v;
    unique case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/rpc_angle.sv
// Angle front end: reduces the angle to a 32-bit phase, splits off the quadrant
// and seeds the first CORDIC cell. Four pipeline stages. Depends on rpc_pkg.
module rpc_angle (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   up_vld,
  output logic                                   up_ld,
  input  logic signed [rpc_pkg::COORD_WIDTH-1:0] point_x,
  input  logic signed [rpc_pkg::COORD_WIDTH-1:0] point_y,
  input  logic signed [rpc_pkg::COORD_WIDTH-1:0] centre_x,
  input  logic signed [rpc_pkg::COORD_WIDTH-1:0] centre_y,
  input  logic signed [rpc_pkg::ANGLE_WIDTH-1:0] turn_angle,
  input  logic                                   angle_in_radians,
  input  logic                                   dn_ld,
  output logic                                   dn_vld,
  output rpc_pkg::cell_t                         dn_cell
);
  import rpc_pkg::*;

  logic [3:0] vld;
  logic [3:0] ld;

  // stage 0
  logic [U_W-1:0]            u_in;
  logic [QP_W-1:0]           qprod;
  logic signed [RADP_W-1:0]  a_s;
  logic signed [RADP_W-1:0]  k_s;
  logic signed [RADP_W-1:0]  radp;
  side_t                     side_in;
  logic [U_W-1:0]            u0;
  logic [QD_W-1:0]           qd0;
  logic [PHASE_W-1:0]        rph0;
  logic                      rad0;
  side_t                     side0;

  // stage 1
  logic [U_W-1:0]            rem_full;
  logic [R_W-1:0]            r1;
  logic [PHASE_W-1:0]        rph1;
  logic                      rad1;
  side_t                     side1;

  // stage 2
  logic [M_W-1:0]            m_val;
  logic [P2_W-1:0]           p2_full;
  logic [PHASE_W-1:0]        p1_2;
  logic [F_W-1:0]            f2;
  logic [PHASE_W-1:0]        rph2;
  logic                      rad2;
  side_t                     side2;

  // stage 3
  logic [PHASE_W-1:0]        phase;
  logic [PHASE_W-1:0]        phase_sh;
  logic [1:0]                quad;
  logic [PHASE_W-1:0]        resid;
  cell_t                     cell_next;
  cell_t                     cell3;

  always_comb begin
    ld[3] = !vld[3] || dn_ld;
    ld[2] = !vld[2] || ld[3];
    ld[1] = !vld[1] || ld[2];
    ld[0] = !vld[0] || ld[1];
  end

  assign up_ld = ld[0];

  always_comb begin
    u_in  = U_W'(turn_angle) + U_W'(DEG_OFFSET);
    qprod = QP_W'(u_in[U_W-1:TURN_HI_SH]) * QP_W'(DEG_RECIP);
    a_s   = RADP_W'(turn_angle);
    k_s   = RADP_W'(RAD_TO_PHASE);
    radp  = a_s * k_s;
    side_in.dx = DIFF_W'(point_x) - DIFF_W'(centre_x);
    side_in.dy = DIFF_W'(point_y) - DIFF_W'(centre_y);
    side_in.cx = centre_x;
    side_in.cy = centre_y;
  end

  always_comb begin
    rem_full = u0 - U_W'(qd0) * U_W'(DEG_TURN);
  end

  always_comb begin
    m_val   = (M_W'(r1) << 4) + M_W'(r1);
    p2_full = P2_W'(m_val) * P2_W'(PH_REM_RECIP);
  end

  always_comb begin
    phase    = rad2 ? rph2 : (p1_2 + PHASE_W'(f2));
    phase_sh = phase + QUAD_HALF;
    quad     = phase_sh[PHASE_W-1:PHASE_W-2];
    resid    = phase - {quad, {(PHASE_W-2){1'b0}}};
    cell_next.x    = XY_W'(CORDIC_GAIN);
    cell_next.y    = '0;
    cell_next.z    = resid;
    cell_next.quad = quad;
    cell_next.zero = (resid == '0);
    cell_next.side = side2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[0]) vld[0] <= up_vld;
      if (ld[1]) vld[1] <= vld[0];
      if (ld[2]) vld[2] <= vld[1];
      if (ld[3]) vld[3] <= vld[2];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      u0    <= u_in;
      qd0   <= qprod[QP_W-1:DEG_RECIP_SH];
      rph0  <= radp[PHASE_W+RAD_SH-1:RAD_SH];
      rad0  <= angle_in_radians;
      side0 <= side_in;
    end
    if (ld[1]) begin
      r1    <= rem_full[R_W-1:0];
      rph1  <= rph0;
      rad1  <= rad0;
      side1 <= side0;
    end
    if (ld[2]) begin
      p1_2  <= PHASE_W'(r1) * PHASE_W'(PH_MUL);
      f2    <= p2_full[P2_W-1:PH_REM_SH];
      rph2  <= rph1;
      rad2  <= rad1;
      side2 <= side1;
    end
    if (ld[3]) begin
      cell3 <= cell_next;
    end
  end

  assign dn_vld  = vld[3];
  assign dn_cell = cell3;

endmodule

FILE: sv/rpc_cell.sv
// One CORDIC micro-rotation cell with its own pipeline register.
// Depends on rpc_pkg for the cell payload type and the arctangent table.
module rpc_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [rpc_pkg::STAGE_IDX_W-1:0] stage_idx,
  input  logic                            up_vld,
  input  rpc_pkg::cell_t                  up_cell,
  output logic                            up_ld,
  input  logic                            dn_ld,
  output logic                            dn_vld,
  output rpc_pkg::cell_t                  dn_cell
);
  import rpc_pkg::*;

  logic                   vld;
  logic                   ld;
  logic signed [XY_W-1:0] x_i;
  logic signed [XY_W-1:0] y_i;
  logic signed [Z_W-1:0]  z_i;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic signed [Z_W-1:0]  ang;
  cell_t                  cell_next;
  cell_t                  cell_q;

  assign ld    = !vld || dn_ld;
  assign up_ld = ld;

  always_comb begin
    x_i = up_cell.x;
    y_i = up_cell.y;
    z_i = up_cell.z;
    xs  = x_i >>> stage_idx;
    ys  = y_i >>> stage_idx;
    ang = signed'(atan_turn(ATAN_IDX_W'(stage_idx)));
    cell_next = up_cell;
    if (!z_i[Z_W-1]) begin
      cell_next.x = x_i - ys;
      cell_next.y = y_i + xs;
      cell_next.z = z_i - ang;
    end else begin
      cell_next.x = x_i + ys;
      cell_next.y = y_i - xs;
      cell_next.z = z_i + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ld) begin
      vld <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      cell_q <= cell_next;
    end
  end

  assign dn_vld  = vld;
  assign dn_cell = cell_q;

endmodule

FILE: sv/rpc_rotate.sv
// Back end: Q2.15 sine/cosine, quadrant fix-up, products, rounding and saturation.
// Five pipeline stages, the last one is the output register. Depends on rpc_pkg.
module rpc_rotate (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   round_to_nearest,
  input  logic                                   up_vld,
  input  rpc_pkg::cell_t                         up_cell,
  output logic                                   up_ld,
  input  logic                                   dn_ld,
  output logic                                   dn_vld,
  output logic signed [rpc_pkg::COORD_WIDTH-1:0] rotated_x,
  output logic signed [rpc_pkg::COORD_WIDTH-1:0] rotated_y,
  output logic                                   saturated
);
  import rpc_pkg::*;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;
  localparam int ONE_Q    = 1 << FRAC_W;
  localparam int HALF_LSB = 1 << (FRAC_W - 1);

  function automatic logic signed [TRIG_W-1:0] to_q15(input logic signed [XY_W-1:0] v);
    logic signed [XY_W:0] vr;
    logic signed [XY_W:0] t;
    logic signed [TRIG_W-1:0] r;
    vr = (XY_W+1)'(v) + (XY_W+1)'(HALF_LSB);
    t  = vr >>> FRAC_W;
    if (t > (XY_W+1)'(ONE_Q)) begin
      r = TRIG_W'(ONE_Q);
    end else if (t < -((XY_W+1)'(ONE_Q))) begin
      r = -(TRIG_W'(ONE_Q));
    end else begin
      r = t[TRIG_W-1:0];
    end
    return r;
  endfunction

  logic [4:0] vld;
  logic [4:0] ld;

  // stage 0
  logic signed [TRIG_W-1:0]      c_v;
  logic signed [TRIG_W-1:0]      s_v;
  logic signed [TRIG_W-1:0]      cs_n;
  logic signed [TRIG_W-1:0]      sn_n;
  logic signed [TRIG_W-1:0]      cs0;
  logic signed [TRIG_W-1:0]      sn0;
  side_t                         side0;
  logic signed [DIFF_W-1:0]      dx0;
  logic signed [DIFF_W-1:0]      dy0;

  // stage 1
  logic signed [PROD_W-1:0]      pxc;
  logic signed [PROD_W-1:0]      pys;
  logic signed [PROD_W-1:0]      pxs;
  logic signed [PROD_W-1:0]      pyc;
  logic signed [COORD_WIDTH-1:0] cx1;
  logic signed [COORD_WIDTH-1:0] cy1;

  // stage 2
  logic signed [SUM_W-1:0]       sx2;
  logic signed [SUM_W-1:0]       sy2;
  logic signed [COORD_WIDTH-1:0] cx2;
  logic signed [COORD_WIDTH-1:0] cy2;

  // stage 3
  logic [SUM_W-1:0]              magx;
  logic [SUM_W-1:0]              magy;
  logic [SUM_W-1:0]              rndx;
  logic [SUM_W-1:0]              rndy;
  logic [MAG_Q_W-1:0]            qx3;
  logic [MAG_Q_W-1:0]            qy3;
  logic                          negx3;
  logic                          negy3;
  logic signed [COORD_WIDTH-1:0] cx3;
  logic signed [COORD_WIDTH-1:0] cy3;

  // stage 4
  logic signed [RES_W-1:0]       qxs;
  logic signed [RES_W-1:0]       qys;
  logic signed [RES_W-1:0]       rx;
  logic signed [RES_W-1:0]       ry;
  logic signed [COORD_WIDTH-1:0] rx_next;
  logic signed [COORD_WIDTH-1:0] ry_next;
  logic                          satx;
  logic                          saty;

  always_comb begin
    ld[4] = !vld[4] || dn_ld;
    ld[3] = !vld[3] || ld[4];
    ld[2] = !vld[2] || ld[3];
    ld[1] = !vld[1] || ld[2];
    ld[0] = !vld[0] || ld[1];
  end

  assign up_ld = ld[0];

  always_comb begin
    if (up_cell.zero) begin
      c_v = TRIG_W'(ONE_Q);
      s_v = '0;
    end else begin
      c_v = to_q15(up_cell.x);
      s_v = to_q15(up_cell.y);
    end
    unique case (up_cell.quad)
      QUAD_0: begin cs_n = c_v;  sn_n = s_v;  end
      QUAD_1: begin cs_n = -s_v; sn_n = c_v;  end
      QUAD_2: begin cs_n = -c_v; sn_n = -s_v; end
      QUAD_3: begin cs_n = s_v;  sn_n = -c_v; end
      default: begin cs_n = c_v; sn_n = s_v;  end
    endcase
  end

  always_comb begin
    dx0 = side0.dx;
    dy0 = side0.dy;
  end

  always_comb begin
    magx = sx2[SUM_W-1] ? SUM_W'(-sx2) : SUM_W'(sx2);
    magy = sy2[SUM_W-1] ? SUM_W'(-sy2) : SUM_W'(sy2);
    rndx = magx + (round_to_nearest ? SUM_W'(HALF_LSB) : '0);
    rndy = magy + (round_to_nearest ? SUM_W'(HALF_LSB) : '0);
  end

  always_comb begin
    qxs = signed'(RES_W'(qx3));
    qys = signed'(RES_W'(qy3));
    rx  = RES_W'(cx3) + (negx3 ? -qxs : qxs);
    ry  = RES_W'(cy3) + (negy3 ? -qys : qys);
    satx = 1'b1;
    saty = 1'b1;
    priority if (rx > RES_W'(COORD_MAX)) begin
      rx_next = COORD_MAX;
    end else if (rx < RES_W'(COORD_MIN)) begin
      rx_next = COORD_MIN;
    end else begin
      rx_next = rx[COORD_WIDTH-1:0];
      satx    = 1'b0;
    end
    priority if (ry > RES_W'(COORD_MAX)) begin
      ry_next = COORD_MAX;
    end else if (ry < RES_W'(COORD_MIN)) begin
      ry_next = COORD_MIN;
    end else begin
      ry_next = ry[COORD_WIDTH-1:0];
      saty    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[0]) vld[0] <= up_vld;
      if (ld[1]) vld[1] <= vld[0];
      if (ld[2]) vld[2] <= vld[1];
      if (ld[3]) vld[3] <= vld[2];
      if (ld[4]) vld[4] <= vld[3];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      cs0   <= cs_n;
      sn0   <= sn_n;
      side0 <= up_cell.side;
    end
    if (ld[1]) begin
      pxc <= PROD_W'(dx0) * PROD_W'(cs0);
      pys <= PROD_W'(dy0) * PROD_W'(sn0);
      pxs <= PROD_W'(dx0) * PROD_W'(sn0);
      pyc <= PROD_W'(dy0) * PROD_W'(cs0);
      cx1 <= side0.cx;
      cy1 <= side0.cy;
    end
    if (ld[2]) begin
      sx2 <= SUM_W'(pxc) - SUM_W'(pys);
      sy2 <= SUM_W'(pxs) + SUM_W'(pyc);
      cx2 <= cx1;
      cy2 <= cy1;
    end
    if (ld[3]) begin
      qx3   <= rndx[SUM_W-1:FRAC_W];
      qy3   <= rndy[SUM_W-1:FRAC_W];
      negx3 <= sx2[SUM_W-1];
      negy3 <= sy2[SUM_W-1];
      cx3   <= cx2;
      cy3   <= cy2;
    end
    if (ld[4]) begin
      rotated_x <= rx_next;
      rotated_y <= ry_next;
      saturated <= satx || saty;
    end
  end

  assign dn_vld = vld[4];

endmodule

FILE: sv/rotate_point_about_centre.sv
// Rotates a point about a centre: angle front end, a row of CORDIC cells, rotate back end.
// One request per cycle, set by the single-register CORDIC cells, while out_stall does
// not back the pipe up. Synchronous reset empties every stage and sets
// round_to_nearest to 1. Depends on rpc_pkg, rpc_angle, rpc_cell and rpc_rotate.
module rotate_point_about_centre (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [rpc_pkg::PADDR_W-1:0]            paddr,
  input  logic [rpc_pkg::PDATA_W-1:0]            pwdata,
  output logic [rpc_pkg::PDATA_W-1:0]            prdata,
  output logic                                   pready,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [rpc_pkg::COORD_WIDTH-1:0] point_x,
  input  logic signed [rpc_pkg::COORD_WIDTH-1:0] point_y,
  input  logic signed [rpc_pkg::COORD_WIDTH-1:0] centre_x,
  input  logic signed [rpc_pkg::COORD_WIDTH-1:0] centre_y,
  input  logic signed [rpc_pkg::ANGLE_WIDTH-1:0] turn_angle,
  input  logic                                   angle_in_radians,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [rpc_pkg::COORD_WIDTH-1:0] rotated_x,
  output logic signed [rpc_pkg::COORD_WIDTH-1:0] rotated_y,
  output logic                                   saturated
);
  import rpc_pkg::*;

  logic                 round_to_nearest;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 ang_ld;
  logic                 chain_vld [CORDIC_STAGES+1];
  logic                 chain_ld  [CORDIC_STAGES+1];
  cell_t                chain_cell [CORDIC_STAGES+1];

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (reg_idx == REG_ROUND) ? PDATA_W'(round_to_nearest) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      round_to_nearest <= 1'b1;
    end else if (cfg_wr && (reg_idx == REG_ROUND)) begin
      round_to_nearest <= pwdata[0];
    end
  end

  rpc_angle u_angle (
    .clk              (clk),
    .rst              (rst),
    .up_vld           (in_valid),
    .up_ld            (ang_ld),
    .point_x          (point_x),
    .point_y          (point_y),
    .centre_x         (centre_x),
    .centre_y         (centre_y),
    .turn_angle       (turn_angle),
    .angle_in_radians (angle_in_radians),
    .dn_ld            (chain_ld[0]),
    .dn_vld           (chain_vld[0]),
    .dn_cell          (chain_cell[0])
  );

  assign in_stall = !ang_ld;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    rpc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .stage_idx (STAGE_IDX_W'(k)),
      .up_vld    (chain_vld[k]),
      .up_cell   (chain_cell[k]),
      .up_ld     (chain_ld[k]),
      .dn_ld     (chain_ld[k+1]),
      .dn_vld    (chain_vld[k+1]),
      .dn_cell   (chain_cell[k+1])
    );
  end

  rpc_rotate u_rotate (
    .clk              (clk),
    .rst              (rst),
    .round_to_nearest (round_to_nearest),
    .up_vld           (chain_vld[CORDIC_STAGES]),
    .up_cell          (chain_cell[CORDIC_STAGES]),
    .up_ld            (chain_ld[CORDIC_STAGES]),
    .dn_ld            (!out_stall),
    .dn_vld           (out_valid),
    .rotated_x        (rotated_x),
    .rotated_y        (rotated_y),
    .saturated        (saturated)
  );

  // input only backs up when the whole pipe is full behind a stalled result
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output is free");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |->
      (rotated_x == COORD_MAX || rotated_x == COORD_MIN ||
       rotated_y == COORD_MAX || rotated_y == COORD_MIN))
    else $error("saturated flag without a clipped coordinate");

  a_round_reset: assert property (@(posedge clk)
    rst |=> round_to_nearest)
    else $error("rounding mode not restored by reset");

endmodule
